[hw/rtl/lpfm_pkg.sv]
// Package for the LRU page frame manager: payload structs, status codes, FSM states.
// No dependencies.
package lpfm_pkg;

  typedef enum logic [2:0] {
    ST_DEFINED  = 3'd0,
    ST_INVALID  = 3'd1,
    ST_HIT      = 3'd2,
    ST_FILL     = 3'd3,
    ST_EVICT    = 3'd4,
    ST_REJECTED = 3'd5
  } status_t;

  localparam logic FUNC_DEFINE = 1'b0;
  localparam logic FUNC_ACCESS = 1'b1;

  localparam logic REG_PAGE_SIZE = 1'b0;
  localparam logic REG_FRAMES    = 1'b1;

  typedef struct packed {
    logic        func;
    logic [3:0]  process_id;
    logic [15:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] linear_address;
    logic [15:0] page_number;
    logic [2:0]  frame_index;
    logic [15:0] evicted_page;
    logic [15:0] fault_count;
    logic [15:0] access_count;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_PAGE,
    S_SCAN,
    S_FINISH
  } fsm_t;

endpackage

[hw/rtl/lpfm_divider.sv]
// Restoring divider, one quotient bit a cycle, for offset over page size.
// Depends on nothing but its ports.
module lpfm_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  logic [15:0] q_r, q_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [12:0] dvs_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [13:0] trial;

  // One shift and subtract step each cycle.
  always_comb begin
    trial    = {rem_r[12:0], q_r[15]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = busy_r && (cnt_r == 5'd1);
  assign quotient = q_nxt;
endmodule

[hw/rtl/lru_page_frame_manager.sv]
// Top level of the LRU page frame manager: control sequencer, process table memory, frame state.
// Depends on lpfm_pkg and lpfm_divider.
//
//  channel | handshake             | word
//  in      | start, busy           | in_word (func, process_id, value)
//  out     | out_valid (strobe)    | out_word (status .. access_count)
//  cfg     | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// A define or an access that is not rejected keeps busy high through the read state, the
// divider steps, the page state, a scan over the configured frames and the finish state. The
// bit-serial divider takes the largest share. A rejected word goes from read straight to finish.
// The process table sits in one synchronous memory with a registered read port.
// Reset clears the frame state; a process's counters are written as zero when it is defined,
// so the table needs no clearing pass.
// The result strobe lasts one cycle, in the cycle after the finish cycle; the receiver cannot
// stall it. Registers are written only while the sequencer is idle.
module lru_page_frame_manager #(
  parameter int NUM_FRAMES = 8,
  parameter int NUM_PROCS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lpfm_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output lpfm_pkg::out_word_t  out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);
  import lpfm_pkg::*;

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

  // Process table memory: start page, size, faults, accesses.
  typedef struct packed {
    logic [15:0] start_pg;
    logic [15:0] size;
    logic [15:0] faults;
    logic [15:0] accesses;
  } proc_ent_t;

  proc_ent_t   ptab [NUM_PROCS];
  proc_ent_t   prd_r;
  logic        pwe;
  logic [PW-1:0] paddr, pwaddr;
  proc_ent_t   pwdata;

  always_ff @(posedge clk) begin
    if (pwe) ptab[pwaddr] <= pwdata;
    prd_r <= ptab[paddr];
  end

  // Configuration registers.
  logic [12:0] psize_r;
  logic [3:0]  nfr_r;
  logic [12:0] ps_eff;
  logic [FW:0] nf_eff;

  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psize_r <= 13'd256;
      nfr_r   <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PAGE_SIZE) psize_r <= cfg_data[12:0];
      else                            nfr_r   <= cfg_data[3:0];
    end
  end

  always_comb begin
    if (psize_r == 13'd0)         ps_eff = 13'd1;
    else if (psize_r > 13'd4096)  ps_eff = 13'd4096;
    else                          ps_eff = psize_r;
    if (nfr_r == 4'd0)                          nf_eff = (FW+1)'(1);
    else if (32'(nfr_r) > NUM_FRAMES)           nf_eff = (FW+1)'(NUM_FRAMES);
    else                                        nf_eff = (FW+1)'(nfr_r);
  end

  // Frame state in flip-flops: each entry is read by the scan index or by the chosen frame index.
  logic [15:0]   fpage_r [NUM_FRAMES];
  logic          fvalid_r [NUM_FRAMES];
  logic [FW-1:0] rank_r [NUM_FRAMES];

  // Sequencer state.
  fsm_t          state_r, state_nxt;
  in_word_t      item_r;
  logic [8:0]    ndef_r;
  logic [15:0]   nfree_r;
  logic [15:0]   nfree_hold_r;
  logic [15:0]   page_r;
  logic [19:0]   lin_r;
  logic [FW:0]   idx_r;
  logic          hit_r, emp_r;
  logic [FW-1:0] hitf_r, empf_r, lruf_r;
  logic [FW-1:0] lrurank_r;
  logic          div_start, div_done;
  logic [15:0]   div_q;
  out_word_t     ow_r, ow_nxt;
  logic          ov_r;

  lpfm_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(item_r.value), .divisor(ps_eff),
    .done(div_done), .quotient(div_q)
  );

  logic        accept;
  logic        pid_ok;
  logic [15:0] acc_inc, flt_inc;
  logic [16:0] ceil_div;
  logic [FW-1:0] sidx;
  logic [FW-1:0] vict;
  logic [32:0] lin_full;
  logic [16:0] page_full;
  logic [16:0] nfree_sum;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign pid_ok = (9'(item_r.process_id) < ndef_r) && (32'(item_r.process_id) < NUM_PROCS);
  assign acc_inc = (prd_r.accesses == 16'hFFFF) ? 16'hFFFF : prd_r.accesses + 16'd1;
  assign flt_inc = (prd_r.faults == 16'hFFFF) ? 16'hFFFF : prd_r.faults + 16'd1;
  assign sidx   = idx_r[FW-1:0];
  assign vict   = hit_r ? hitf_r : (emp_r ? empf_r : lruf_r);

  // Next state, memory port and result assembly.
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    pwe       = 1'b0;
    pwaddr    = PW'(item_r.process_id);
    paddr     = PW'(item_r.process_id);
    pwdata    = prd_r;
    ow_nxt    = '0;
    lin_full  = '0;
    page_full = '0;
    nfree_sum = '0;
    ceil_div  = '0;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_READ;
      S_READ: begin
        if (item_r.func == FUNC_DEFINE) begin
          paddr = ndef_r[PW-1:0];
          state_nxt = (32'(ndef_r) < NUM_PROCS) ? S_DIV : S_FINISH;
        end else begin
          state_nxt = pid_ok ? S_DIV : S_FINISH;
        end
        div_start = 1'b1;
      end
      S_DIV: begin
        // Wait for quotient; defines reuse it for the page count.
        if (div_done) state_nxt = S_PAGE;
      end
      S_PAGE: state_nxt = S_SCAN;
      S_SCAN: if (idx_r == nf_eff) state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    // Result and table write in the final cycle.
    if (state_r == S_FINISH) begin
      if (item_r.func == FUNC_DEFINE) begin
        if (32'(ndef_r) < NUM_PROCS) begin
          // A new process starts with both counters at zero.
          paddr             = ndef_r[PW-1:0];
          pwaddr            = ndef_r[PW-1:0];
          pwe               = 1'b1;
          pwdata.start_pg   = nfree_r;
          pwdata.size       = item_r.value;
          pwdata.faults     = '0;
          pwdata.accesses   = '0;
          ow_nxt.status     = ST_DEFINED;
          ow_nxt.page_number = nfree_r;
          lin_full          = 33'(nfree_r) * 33'(ps_eff);
          ow_nxt.linear_address = (lin_full > 33'd1048575) ? 20'hFFFFF : lin_full[19:0];
          ow_nxt.fault_count  = '0;
          ow_nxt.access_count = '0;
        end else begin
          ow_nxt.status = ST_REJECTED;
        end
      end else if (!pid_ok) begin
        ow_nxt.status = ST_REJECTED;
      end else begin
        pwe             = 1'b1;
        pwdata.accesses = acc_inc;
        ow_nxt.access_count   = acc_inc;
        ow_nxt.linear_address = lin_r;
        ow_nxt.fault_count    = prd_r.faults;
        if (item_r.value >= prd_r.size) begin
          ow_nxt.status = ST_INVALID;
        end else begin
          ow_nxt.page_number = page_r;
          ow_nxt.frame_index = 3'(vict);
          if (hit_r) ow_nxt.status = ST_HIT;
          else begin
            pwdata.faults      = flt_inc;
            ow_nxt.fault_count = flt_inc;
            if (emp_r) ow_nxt.status = ST_FILL;
            else begin
              ow_nxt.status       = ST_EVICT;
              ow_nxt.evicted_page = fpage_r[lruf_r];
            end
          end
        end
      end
    end
    // Page count for define: ceil(value/ps) = q + (remainder nonzero).
    ceil_div  = 17'(div_q) + ((32'(div_q) * 32'(ps_eff) != 32'(item_r.value)) ? 17'd1 : 17'd0);
    nfree_sum = 17'(nfree_r) + ceil_div;
    page_full = 17'(prd_r.start_pg) + 17'(div_q);
  end

  // Sequencer registers and frame scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ndef_r  <= '0;
      nfree_r <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        fvalid_r[i] <= 1'b0;
        rank_r[i]   <= FW'(i);
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= (state_r == S_FINISH);
      if (accept) item_r <= in_word;
      if (state_r == S_PAGE) begin
        idx_r <= '0;
        hit_r <= 1'b0;
        emp_r <= 1'b0;
        lruf_r <= '0;
        lrurank_r <= '0;
        page_r <= (page_full > 17'd65535) ? 16'hFFFF : page_full[15:0];
        lin_r  <= (33'(prd_r.start_pg) * 33'(ps_eff) + 33'(item_r.value) > 33'd1048575)
                  ? 20'hFFFFF
                  : 20'(33'(prd_r.start_pg) * 33'(ps_eff) + 33'(item_r.value));
        if (item_r.func == FUNC_DEFINE) nfree_hold_r <= (nfree_sum > 17'd65535) ? 16'hFFFF
                                                        : nfree_sum[15:0];
      end
      if (state_r == S_SCAN && idx_r != nf_eff) begin
        idx_r <= idx_r + (FW+1)'(1);
        if (!hit_r && fvalid_r[sidx] && fpage_r[sidx] == page_r) begin
          hit_r  <= 1'b1;
          hitf_r <= sidx;
        end
        if (!emp_r && !fvalid_r[sidx]) begin
          emp_r  <= 1'b1;
          empf_r <= sidx;
        end
        if (idx_r == '0 || rank_r[sidx] > lrurank_r) begin
          lruf_r    <= sidx;
          lrurank_r <= rank_r[sidx];
        end
      end
      if (state_r == S_FINISH) begin
        if (item_r.func == FUNC_DEFINE) begin
          if (32'(ndef_r) < NUM_PROCS) begin
            ndef_r  <= ndef_r + 9'd1;
            nfree_r <= nfree_hold_r;
          end
        end else if (pid_ok && item_r.value < prd_r.size) begin
          // Promote the touched frame to most recent.
          for (int i = 0; i < NUM_FRAMES; i++)
            if (rank_r[i] < rank_r[vict]) rank_r[i] <= rank_r[i] + FW'(1);
          rank_r[vict] <= '0;
          if (!hit_r) begin
            fvalid_r[vict] <= 1'b1;
          end
        end
      end
    end
    if (state_r == S_FINISH && item_r.func == FUNC_ACCESS && pid_ok
        && item_r.value < prd_r.size && !hit_r)
      fpage_r[vict] <= page_r;
    ow_r <= ow_nxt;
  end

  assign out_valid = ov_r;
  assign out_word  = ow_r;

  // The result strobe follows every finish cycle.
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |=> out_valid) else $error("missing result strobe");
  // Busy stays high during the scan, so no new item is taken then.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> busy) else $error("busy dropped during scan");
  // Defined process count never exceeds the table depth.
  a_ndef: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ndef_r) <= NUM_PROCS) else $error("process count overflow");
endmodule

[tb/sv/lru_page_frame_manager_test.sv]
// Self-checking testbench for the LRU page frame manager: process definition, address
// translation, LRU frame replacement and fault and access counters, against a behavioural predictor.
// Depends on lpfm_pkg and the lru_page_frame_manager RTL.
module lru_page_frame_manager_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lpfm_pkg::*;

  localparam int NFR = 8;
  localparam int NPR = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_valid;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  lru_page_frame_manager dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: a copy of the frame table, process table and settings.
  logic [12:0] pg_size_reg;
  logic [3:0]  frames_reg;
  logic [15:0] fr_page [NFR];
  logic        fr_valid [NFR];
  int          fr_rank [NFR];
  logic [15:0] pr_start [NPR];
  logic [15:0] pr_size [NPR];
  logic [15:0] pr_faults [NPR];
  logic [15:0] pr_acc [NPR];
  int          next_page;
  int          num_defined;

  out_word_t expected_words[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;

  function automatic logic [15:0] bump16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Work out the result of one word and update the predictor state.
  function automatic out_word_t translate_word(in_word_t w);
    out_word_t r;
    longint ps, nf, lin, pg, pages;
    int pid, fr, best;
    bit found;
    r = '0;
    ps = (pg_size_reg == 0) ? 1 : (pg_size_reg > 4096) ? 4096 : pg_size_reg;
    nf = (frames_reg == 0) ? 1 : (frames_reg > NFR) ? NFR : frames_reg;
    r.status = ST_REJECTED;
    if (w.func == FUNC_DEFINE) begin
      if (num_defined < NPR) begin
        pages = (w.value + ps - 1) / ps;
        pr_start[num_defined] = next_page[15:0];
        pr_size[num_defined] = w.value;
        r.status = ST_DEFINED;
        r.page_number = next_page[15:0];
        lin = next_page * ps;
        r.linear_address = (lin > 20'hFFFFF) ? 20'hFFFFF : lin[19:0];
        next_page = (next_page + pages > 65535) ? 65535 : int'(next_page + pages);
        r.fault_count = pr_faults[num_defined];
        r.access_count = pr_acc[num_defined];
        num_defined++;
      end
    end else if (w.process_id < num_defined) begin
      pid = w.process_id;
      pr_acc[pid] = bump16(pr_acc[pid]);
      lin = longint'(pr_start[pid]) * ps + w.value;
      r.linear_address = (lin > 20'hFFFFF) ? 20'hFFFFF : lin[19:0];
      if (w.value >= pr_size[pid]) begin
        r.status = ST_INVALID;
      end else begin
        pg = longint'(pr_start[pid]) + w.value / ps;
        if (pg > 65535) pg = 65535;
        r.page_number = pg[15:0];
        found = 0;
        fr = 0;
        for (int i = 0; i < nf; i++)
          if (!found && fr_valid[i] && fr_page[i] == pg[15:0]) begin
            found = 1;
            fr = i;
          end
        if (found) begin
          r.status = ST_HIT;
        end else begin
          pr_faults[pid] = bump16(pr_faults[pid]);
          for (int i = 0; i < nf; i++)
            if (!found && !fr_valid[i]) begin
              found = 1;
              fr = i;
            end
          if (found) begin
            r.status = ST_FILL;
          end else begin
            best = 0;
            for (int i = 1; i < nf; i++)
              if (fr_rank[i] > fr_rank[best]) best = i;
            fr = best;
            r.evicted_page = fr_page[best];
            r.status = ST_EVICT;
          end
          fr_page[fr] = pg[15:0];
          fr_valid[fr] = 1'b1;
        end
        // Move the used frame to the front of the recency order.
        for (int i = 0; i < NFR; i++)
          if (fr_rank[i] < fr_rank[fr]) fr_rank[i]++;
        fr_rank[fr] = 0;
        r.frame_index = fr[2:0];
      end
      r.fault_count = pr_faults[pid];
      r.access_count = pr_acc[pid];
    end
    return r;
  endfunction

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p", out_word);
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        if (out_word !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", e, out_word);
        end
      end
    end
  end

  always @(posedge clk)
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end

  // Send one word, with a random gap before it per the current idle rate.
  // Start is lowered once busy drops, before the next word can be driven.
  task automatic send_word(logic func, logic [3:0] pid, logic [15:0] val);
    in_word_t w;
    w.func = func;
    w.process_id = pid;
    w.value = val;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(translate_word(w));
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block drain before a register write.
  task automatic wait_idle();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_PAGE_SIZE) pg_size_reg = data[12:0];
    else frames_reg = data[3:0];
  endtask

  // Reset the block and the predictor together.
  task automatic reset_block();
    pg_size_reg = 13'd256;
    frames_reg = 4'd4;
    for (int i = 0; i < NFR; i++) begin
      fr_page[i] = '0;
      fr_valid[i] = 1'b0;
      fr_rank[i] = i;
    end
    for (int i = 0; i < NPR; i++) begin
      pr_start[i] = '0;
      pr_size[i] = '0;
      pr_faults[i] = '0;
      pr_acc[i] = '0;
    end
    next_page = 0;
    num_defined = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Directed: undefined process, size extremes, hits, fills, evictions, invalid offsets.
  task automatic test_directed();
    send_word(FUNC_ACCESS, 4'd0, 16'd0);
    send_word(FUNC_DEFINE, 4'd15, 16'd1000);
    send_word(FUNC_DEFINE, 4'd0, 16'd0);
    send_word(FUNC_DEFINE, 4'd9, 16'd65535);
    send_word(FUNC_ACCESS, 4'd0, 16'd0);
    send_word(FUNC_ACCESS, 4'd0, 16'd999);
    send_word(FUNC_ACCESS, 4'd0, 16'd1000);
    send_word(FUNC_ACCESS, 4'd1, 16'd0);
    send_word(FUNC_ACCESS, 4'd0, 16'd300);
    send_word(FUNC_ACCESS, 4'd0, 16'd600);
    send_word(FUNC_ACCESS, 4'd0, 16'd900);
    send_word(FUNC_ACCESS, 4'd2, 16'd65534);
    send_word(FUNC_ACCESS, 4'd2, 16'd65535);
    send_word(FUNC_ACCESS, 4'd0, 16'd10);
    send_word(FUNC_ACCESS, 4'd2, 16'd0);
    send_word(FUNC_ACCESS, 4'd15, 16'hFFFF);
  endtask

  // Random traffic in phases, each with its own page size and frame count.
  task automatic test_random(int count);
    int r;
    logic [3:0] pid;
    logic [15:0] val;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        r = $urandom_range(3);
        val = (r == 0) ? 16'($urandom) : (r == 1) ? 16'($urandom_range(16)) :
              16'($urandom_range(8192));
        send_word(FUNC_DEFINE, 4'($urandom), val);
      end else begin
        pid = (num_defined > 0 && $urandom_range(9) != 0) ?
              4'($urandom_range(num_defined - 1)) : 4'($urandom);
        if (pid < num_defined && $urandom_range(9) != 0 && pr_size[pid] != 0)
          val = 16'($urandom_range(pr_size[pid] - 1) % (pg_size_reg * 12 + 1));
        else
          val = 16'($urandom);
        send_word(FUNC_ACCESS, pid, val);
      end
    end
  endtask

  initial begin
    reset_block();
    send_idle_pct = 23;
    test_directed();
    write_reg(REG_PAGE_SIZE, 16'd1);
    write_reg(REG_FRAMES, 16'd1);
    test_random(60);
    write_reg(REG_PAGE_SIZE, 16'd4096);
    write_reg(REG_FRAMES, 16'd8);
    test_random(90);
    send_idle_pct = 87;
    write_reg(REG_PAGE_SIZE, 16'd0);
    write_reg(REG_FRAMES, 16'd0);
    test_random(60);
    write_reg(REG_PAGE_SIZE, 16'hFFFF);
    write_reg(REG_FRAMES, 16'd15);
    test_random(90);
    send_idle_pct = 0;
    write_reg(REG_PAGE_SIZE, 16'd100);
    write_reg(REG_FRAMES, 16'd3);
    test_random(120);
    write_reg(REG_PAGE_SIZE, 16'(1 << $urandom_range(12)));
    write_reg(REG_FRAMES, 16'd8);
    test_random(110);
    wait_idle();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

[sim.f]
hw/rtl/lpfm_pkg.sv
hw/rtl/lpfm_divider.sv
hw/rtl/lru_page_frame_manager.sv
tb/sv/lru_page_frame_manager_test.sv
